>>> design/vgrt_pkg.sv
// package for the voxel grid ray walker: widths, codes, state enum
// used by vgrt_div and the top level
`default_nettype none
package vgrt_pkg;
  localparam int CellBitsDef = 16;
  localparam int FracBitsDef = 16;
  localparam int DistW       = 48;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [7:0] MaxStepsRst = 8'd30;

  localparam logic [1:0] StQuery  = 2'd0;
  localparam logic [1:0] StHit    = 2'd1;
  localparam logic [1:0] StMiss   = 2'd2;
  localparam logic [1:0] StNoRay  = 2'd3;

  localparam logic [0:0] RegMaxSteps  = 1'b0;
  localparam logic [0:0] RegEmptyCode = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SIDE, S_STEP, S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;
endpackage
`default_nettype wire

>>> design/vgrt_div.sv
// restoring divider: 2^(15+FRAC_BITS) / mag, one quotient bit per cycle
// depends on vgrt_pkg
`default_nettype none
module vgrt_div #(
  parameter int FRAC_BITS = vgrt_pkg::FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] mag_i,
  output vgrt_pkg::div_ctrl_t ctrl_o,
  output logic [vgrt_pkg::DistW-1:0] quot_o
);
  localparam int NB = 16 + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);
  logic [CW-1:0] cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [NB-1:0] quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [16:0] sh;
  logic bit_in;

  always_comb begin
    bit_in = (cnt_q == CW'(NB));
    sh = {rem_q[15:0], bit_in};
    cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(NB); rem_d = '0; quo_d = '0; den_d = mag_i; busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[NB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign ctrl_o = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = vgrt_pkg::DistW'(quo_q);
endmodule
`default_nettype wire

>>> design/voxel_grid_ray_traversal.sv
// voxel grid ray walker top level: sequencer, axis state, shared divider
// depends on vgrt_pkg and vgrt_div
//
// channel  | dir | contents
// s_axis   | in  | tuser kind, tdata origin xyz, dir xyz, cell_type
// m_axis   | out | tdata status, cell xyz, hit_type, face
// cfg      | in  | wr_en, index, data
//
// start: per axis a divider start, the divide steps (one per quotient bit), done and
// the side distance multiply, or the side state alone for a zero component; then a
// step state and the output state, after which the result is valid
// answer: a step state when it steps, then the output state, after which the result is valid
// reset clears control state; a result waits in the output register until taken,
// and no input is taken while busy or while a result waits
`default_nettype none
module voxel_grid_ray_traversal #(
  parameter int CELL_BITS = vgrt_pkg::CellBitsDef,
  parameter int FRAC_BITS = vgrt_pkg::FracBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, cell_type
  input  wire logic [151:0] s_axis_tdata,
  // kind
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, cell_x, cell_y, cell_z, hit_type, face
  output logic [63:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [7:0]   cfg_data_i
);
  localparam int DW = vgrt_pkg::DistW;
  localparam int FM = (1 << FRAC_BITS);

  vgrt_pkg::state_e st_q, st_d;
  logic [7:0] max_steps_q, empty_code_q, steps_left_q;
  logic ray_active_q;
  logic [2:0] last_face_q;
  logic [1:0] ax_q;
  logic [CELL_BITS-1:0] cell_q [3];
  logic [DW-1:0] side_q [3];
  logic [DW-1:0] len_q [3];
  logic neg_q [3];
  logic [FRAC_BITS-1:0] frac_q [3];
  logic [15:0] mag_q [3];
  logic [63:0] out_q;
  logic out_v_q;

  logic div_start;
  vgrt_pkg::div_ctrl_t dctl;
  logic [DW-1:0] quot;

  vgrt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .mag_i(mag_q[ax_q]), .ctrl_o(dctl), .quot_o(quot)
  );

  logic acc;
  assign s_axis_tready = (st_q == vgrt_pkg::S_IDLE) && !out_v_q;
  assign acc = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      vgrt_pkg::S_IDLE: if (acc) begin
        if (!s_axis_tuser) st_d = vgrt_pkg::S_DIV;
        else if (ray_active_q && s_axis_tdata[151:144] == empty_code_q &&
                 steps_left_q > 8'd1) st_d = vgrt_pkg::S_STEP;
        else st_d = vgrt_pkg::S_OUT;
      end
      vgrt_pkg::S_DIV: if (mag_q[ax_q] == 16'd0 || dctl.done) st_d = vgrt_pkg::S_SIDE;
      vgrt_pkg::S_SIDE: st_d = (ax_q == 2'd2) ? vgrt_pkg::S_STEP : vgrt_pkg::S_DIV;
      vgrt_pkg::S_STEP: st_d = vgrt_pkg::S_OUT;
      vgrt_pkg::S_OUT: st_d = vgrt_pkg::S_IDLE;
      default: st_d = vgrt_pkg::S_IDLE;
    endcase
  end

  // outputs of sequencer
  logic div_run_q;
  always_comb begin
    div_start = (st_q == vgrt_pkg::S_DIV) && !div_run_q && mag_q[ax_q] != 16'd0;
  end

  logic [1:0] sel;
  logic [DW:0] sum;
  logic [FRAC_BITS:0] fr_m;
  logic [DW+FRAC_BITS:0] prod;
  always_comb begin
    if (side_q[0] <= side_q[1] && side_q[0] <= side_q[2]) sel = 2'd0;
    else if (side_q[1] <= side_q[2]) sel = 2'd1;
    else sel = 2'd2;
    sum = {1'b0, side_q[sel]} + {1'b0, len_q[sel]};
    fr_m = neg_q[ax_q] ? {1'b0, frac_q[ax_q]}
                       : (FRAC_BITS+1)'(FM) - {1'b0, frac_q[ax_q]};
    prod = (DW+FRAC_BITS+1)'(fr_m) * (DW+FRAC_BITS+1)'(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= vgrt_pkg::S_IDLE;
      max_steps_q <= vgrt_pkg::MaxStepsRst; empty_code_q <= '0;
      steps_left_q <= '0; ray_active_q <= 1'b0; last_face_q <= '0;
      ax_q <= '0; out_v_q <= 1'b0; div_run_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          vgrt_pkg::RegMaxSteps:  max_steps_q <= cfg_data_i;
          vgrt_pkg::RegEmptyCode: empty_code_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (div_start) div_run_q <= 1'b1;
      if (dctl.done) div_run_q <= 1'b0;
      case (st_q)
        vgrt_pkg::S_IDLE: if (acc) begin
          ax_q <= '0;
          if (!s_axis_tuser) begin
            steps_left_q <= max_steps_q; ray_active_q <= 1'b1;
          end else if (ray_active_q) begin
            if (s_axis_tdata[151:144] != empty_code_q) ray_active_q <= 1'b0;
            else if (steps_left_q <= 8'd1) begin
              steps_left_q <= '0; ray_active_q <= 1'b0;
            end else steps_left_q <= steps_left_q - 8'd1;
          end
        end
        vgrt_pkg::S_SIDE: ax_q <= ax_q + 2'd1;
        vgrt_pkg::S_STEP: last_face_q <= {sel, 1'b0} + {2'b0, neg_q[sel]};
        vgrt_pkg::S_OUT: out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  logic [1:0] ost_q;
  logic [7:0] oht_q;
  always_ff @(posedge clk_i) begin
    case (st_q)
      vgrt_pkg::S_IDLE: if (acc) begin
        if (!s_axis_tuser) begin
          for (int a = 0; a < 3; a++) begin
            cell_q[a] <= CELL_BITS'(signed'(s_axis_tdata[32*a+FRAC_BITS +: 32-FRAC_BITS]));
            frac_q[a] <= s_axis_tdata[32*a +: FRAC_BITS];
            neg_q[a] <= s_axis_tdata[96+16*a+15];
            mag_q[a] <= s_axis_tdata[96+16*a+15]
                        ? 16'(17'h10000 - {1'b0, s_axis_tdata[96+16*a +: 16]})
                        : s_axis_tdata[96+16*a +: 16];
          end
        end
        if (!s_axis_tuser) ost_q <= vgrt_pkg::StQuery;
        else if (!ray_active_q) ost_q <= vgrt_pkg::StNoRay;
        else if (s_axis_tdata[151:144] != empty_code_q) ost_q <= vgrt_pkg::StHit;
        else if (steps_left_q <= 8'd1) ost_q <= vgrt_pkg::StMiss;
        else ost_q <= vgrt_pkg::StQuery;
        oht_q <= (s_axis_tuser && ray_active_q && s_axis_tdata[151:144] != empty_code_q)
                 ? s_axis_tdata[151:144] : 8'd0;
      end
      vgrt_pkg::S_SIDE: begin
        if (mag_q[ax_q] == 16'd0) begin
          len_q[ax_q] <= vgrt_pkg::DistMax; side_q[ax_q] <= vgrt_pkg::DistMax;
        end else begin
          len_q[ax_q] <= quot;
          side_q[ax_q] <= DW'(prod >> FRAC_BITS);
        end
      end
      vgrt_pkg::S_STEP: begin
        side_q[sel] <= sum[DW] ? vgrt_pkg::DistMax : sum[DW-1:0];
        cell_q[sel] <= neg_q[sel] ? cell_q[sel] - 1'b1 : cell_q[sel] + 1'b1;
      end
      vgrt_pkg::S_OUT: begin
        if (ost_q == vgrt_pkg::StNoRay) out_q <= {62'd0, ost_q};
        else out_q <= {3'd0, last_face_q, oht_q,
                       16'(signed'(cell_q[2])), 16'(signed'(cell_q[1])),
                       16'(signed'(cell_q[0])), ost_q};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
endmodule
`default_nettype wire

>>> design/vgrt_checker.sv
// port-level checker for the voxel grid ray walker, bound to the top level
// depends on nothing but the top-level ports
`default_nettype none
module vgrt_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken before result");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while result pending");
  a_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[60:58] != 3'd6 && m_axis_tdata[60:58] != 3'd7)
    else $error("bad face code");
endmodule

bind voxel_grid_ray_traversal vgrt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> tb/sv/voxel_grid_ray_traversal_test.sv
// testbench for the voxel grid ray walker: directed rows, then random ray walks
// checked against a cycle-free walker model; depends on vgrt_pkg and the rtl
`default_nettype none
module voxel_grid_ray_traversal_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  face;
    logic [7:0]  ht;
    logic [15:0] cz;
    logic [15:0] cy;
    logic [15:0] cx;
    logic [1:0]  status;
  } walk_res_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
    logic [7:0]  ct;
    logic        chk;
    walk_res_t   exp;
  } stim_row_t;

  localparam walk_res_t NoExp = '0;
  localparam stim_row_t DirRows [16] = '{
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b1,
      '{status: vgrt_pkg::StNoRay, default: '0}},
    '{1'b0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b1,
      '{status: vgrt_pkg::StQuery, cx: 16'd1, default: '0}},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b1,
      '{status: vgrt_pkg::StQuery, cx: 16'd2, default: '0}},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'hff, 1'b1,
      '{status: vgrt_pkg::StHit, cx: 16'd2, ht: 8'hff, default: '0}},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b1,
      '{status: vgrt_pkg::StNoRay, default: '0}},
    '{1'b0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 16'h7fff, 16'h8000, 16'h0001,
      8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h80, 1'b0, NoExp},
    '{1'b0, 32'h0000ffff, 32'hffff0000, 32'h00008000, 16'hffff, 16'hffff, 16'hffff,
      8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b0, NoExp},
    '{1'b0, 32'h80008000, 32'h12345678, 32'hfedcba98, 16'h0000, 16'h8000, 16'h0000,
      8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h00, 1'b0, NoExp},
    '{1'b1, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 8'h01, 1'b0, NoExp}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = vgrt_pkg::RegMaxSteps;
  logic [7:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  voxel_grid_ray_traversal i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // walker model state
  logic [7:0]  max_steps_q = vgrt_pkg::MaxStepsRst;
  logic [7:0]  empty_code_q = 8'd0;
  logic [15:0] cell_pos [3] = '{default: '0};
  logic [63:0] side_dist [3] = '{default: '0};
  logic [63:0] step_len [3] = '{default: '0};
  bit          step_neg [3] = '{default: 1'b0};
  logic [7:0]  steps_left = '0;
  bit          ray_on = 1'b0;
  logic [2:0]  last_face = '0;

  walk_res_t expected_q [$];
  int errors = 0, checked = 0, rays = 0, hits = 0, misses = 0;
  bit long_hold_req = 1'b0;
  bit tx_burst = 1'b0;

  function automatic void take_step();
    int a;
    logic [63:0] s;
    if (side_dist[0] <= side_dist[1] && side_dist[0] <= side_dist[2]) a = 0;
    else if (side_dist[1] <= side_dist[2]) a = 1;
    else a = 2;
    s = side_dist[a] + step_len[a];
    side_dist[a] = (s > {16'd0, vgrt_pkg::DistMax}) ? {16'd0, vgrt_pkg::DistMax} : s;
    cell_pos[a] = step_neg[a] ? cell_pos[a] - 16'd1 : cell_pos[a] + 16'd1;
    last_face = 3'(a * 2 + (step_neg[a] ? 1 : 0));
  endfunction

  function automatic void start_axis(int a, logic [31:0] org, logic [15:0] dir);
    logic [63:0] frac, mag;
    frac = {48'd0, org[15:0]};
    cell_pos[a] = org[31:16];
    step_neg[a] = dir[15];
    mag = dir[15] ? 64'h10000 - {48'd0, dir} : {48'd0, dir};
    if (mag == 0) begin
      step_len[a] = {16'd0, vgrt_pkg::DistMax};
      side_dist[a] = {16'd0, vgrt_pkg::DistMax};
    end else begin
      step_len[a] = 64'h8000_0000 / mag;
      if (dir[15]) side_dist[a] = (frac * step_len[a]) >> 16;
      else side_dist[a] = ((64'h10000 - frac) * step_len[a]) >> 16;
    end
  endfunction

  function automatic walk_res_t walk_next(stim_row_t it);
    walk_res_t r;
    r = '0;
    if (!it.kind) begin
      start_axis(0, it.ox, it.dx);
      start_axis(1, it.oy, it.dy);
      start_axis(2, it.oz, it.dz);
      steps_left = max_steps_q;
      ray_on = 1'b1;
      take_step();
      r.status = vgrt_pkg::StQuery;
      rays++;
    end else if (!ray_on) begin
      r.status = vgrt_pkg::StNoRay;
      return r;
    end else if (it.ct != empty_code_q) begin
      ray_on = 1'b0;
      r.status = vgrt_pkg::StHit;
      r.ht = it.ct;
      hits++;
    end else if (steps_left <= 1) begin
      steps_left = 0;
      ray_on = 1'b0;
      r.status = vgrt_pkg::StMiss;
      misses++;
    end else begin
      steps_left--;
      take_step();
      r.status = vgrt_pkg::StQuery;
    end
    r.cx = cell_pos[0];
    r.cy = cell_pos[1];
    r.cz = cell_pos[2];
    r.face = last_face;
    return r;
  endfunction

  task automatic send_item(stim_row_t it);
    int gap;
    walk_res_t r;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {it.ct, it.dz, it.dy, it.dx, it.oz, it.oy, it.ox};
    do @(posedge clk_i); while (!s_axis_tready);
    r = walk_next(it);
    expected_q.push_back(it.chk ? it.exp : r);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == vgrt_pkg::RegMaxSteps) max_steps_q = val;
    else empty_code_q = val;
  endtask

  function automatic logic [15:0] rand_dir();
    if ($urandom_range(0, 7) == 0) return 16'd0;
    return 16'($urandom());
  endfunction

  task automatic random_rays(int n_items);
    stim_row_t it;
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      tx_burst = ($urandom_range(0, 5) == 0);
      it = '0;
      it.ox = $urandom();
      it.oy = $urandom();
      it.oz = $urandom();
      if ($urandom_range(0, 1)) begin
        it.ox[31:20] = '0;
        it.oy[31:20] = '1;
      end
      it.dx = rand_dir();
      it.dy = rand_dir();
      it.dz = rand_dir();
      send_item(it);
      sent++;
      len = $urandom_range(0, 40);
      for (int k = 0; k < len && sent < n_items; k++) begin
        it.kind = 1'b1;
        it.ct = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : empty_code_q;
        if ($urandom_range(0, 30) == 0) it.kind = 1'($urandom());
        send_item(it);
        sent++;
        if (sent == 150) long_hold_req = 1'b1;
      end
    end
  endtask

  // result side: checks and random stalls
  int rx_wait = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    walk_res_t got, want;
    logic nxt;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[60:0];
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $realtime, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status || got.cx != want.cx || got.cy != want.cy ||
            got.cz != want.cz || got.ht != want.ht || got.face != want.face) begin
          $display("%0t mismatch: expected st=%0d c=(%h,%h,%h) t=%h f=%0d, actual st=%0d c=(%h,%h,%h) t=%h f=%0d",
                   $realtime, want.status, want.cx, want.cy, want.cz, want.ht, want.face,
                   got.status, got.cx, got.cy, got.cz, got.ht, got.face);
          errors++;
        end
      end
      rx_wait = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 17);
    end
    if (long_hold_req && hold_cnt == 0) begin
      long_hold_req = 1'b0;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      nxt = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
    end
    m_axis_tready <= nxt;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirRows[i]) send_item(DirRows[i]);
    write_reg(vgrt_pkg::RegMaxSteps, 8'd1);
    random_rays(100);
    write_reg(vgrt_pkg::RegEmptyCode, 8'hff);
    write_reg(vgrt_pkg::RegMaxSteps, 8'd255);
    random_rays(200);
    write_reg(vgrt_pkg::RegMaxSteps, 8'd0);
    write_reg(vgrt_pkg::RegEmptyCode, 8'h00);
    random_rays(60);
    write_reg(vgrt_pkg::RegMaxSteps, 8'($urandom_range(2, 40)));
    write_reg(vgrt_pkg::RegEmptyCode, 8'($urandom()));
    random_rays(340);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d results over %0d rays: %0d hits, %0d misses",
             checked, rays, hits, misses);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
